@@ hw/rtl/pls_pkg.sv @@
package pls_pkg;

  // Default widths of the line counter and of byte offsets.
  localparam int LINE_BITS_DEF = 16;
  localparam int POS_BITS_DEF  = 20;

  // Width of the token kind field.
  localparam int KIND_W = 5;

  // Entries in the result queue. Must be a power of two and at least two,
  // since one source byte can complete two tokens.
  localparam int QUEUE_DEPTH = 4;

  // Default width of one queued result: last flag plus the packed fields.
  localparam int QUEUE_W_DEF = 1 + KIND_W + LINE_BITS_DEF + 2 * POS_BITS_DEF;

  // Source characters that steer the scanner.
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_LESS    = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_STAR    = 8'h2A;

  typedef enum logic [KIND_W-1:0] {
    K_LPAREN        = 5'd0,
    K_RPAREN        = 5'd1,
    K_LBRACE        = 5'd2,
    K_RBRACE        = 5'd3,
    K_COMMA         = 5'd4,
    K_DOT           = 5'd5,
    K_MINUS         = 5'd6,
    K_PLUS          = 5'd7,
    K_SEMI          = 5'd8,
    K_STAR          = 5'd9,
    K_SLASH         = 5'd10,
    K_BANG          = 5'd11,
    K_BANG_EQUAL    = 5'd12,
    K_LESS          = 5'd13,
    K_LESS_EQUAL    = 5'd14,
    K_GREATER       = 5'd15,
    K_GREATER_EQUAL = 5'd16,
    K_EQUAL         = 5'd17,
    K_EQUAL_EQUAL   = 5'd18,
    K_STRING        = 5'd19,
    K_EOF           = 5'd20,
    K_BAD           = 5'd21,
    K_UNTERM        = 5'd22
  } kind_t;

  typedef enum logic [7:0] {
    MODE_NORMAL  = 8'b0000_0001,
    MODE_BANG    = 8'b0000_0010,
    MODE_LESS    = 8'b0000_0100,
    MODE_GREATER = 8'b0000_1000,
    MODE_EQUAL   = 8'b0001_0000,
    MODE_SLASH   = 8'b0010_0000,
    MODE_COMMENT = 8'b0100_0000,
    MODE_STRING  = 8'b1000_0000
  } mode_t;

  // What a byte does when it is scanned from the normal mode.
  typedef struct packed {
    logic  emit;
    kind_t kind;
    mode_t mode;
    logic  newline;
    logic  quote;
  } normal_t;

  // Write strobes from the scanner into the result queue.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic normal_t lex_byte(logic [7:0] c);
    normal_t r;
    r.emit    = 1'b1;
    r.kind    = K_BAD;
    r.mode    = MODE_NORMAL;
    r.newline = 1'b0;
    r.quote   = 1'b0;
    case (c)
      CH_LPAREN:  r.kind = K_LPAREN;
      CH_RPAREN:  r.kind = K_RPAREN;
      CH_LBRACE:  r.kind = K_LBRACE;
      CH_RBRACE:  r.kind = K_RBRACE;
      CH_COMMA:   r.kind = K_COMMA;
      CH_DOT:     r.kind = K_DOT;
      CH_MINUS:   r.kind = K_MINUS;
      CH_PLUS:    r.kind = K_PLUS;
      CH_SEMI:    r.kind = K_SEMI;
      CH_STAR:    r.kind = K_STAR;
      CH_BANG: begin
        r.emit = 1'b0;
        r.mode = MODE_BANG;
      end
      CH_LESS: begin
        r.emit = 1'b0;
        r.mode = MODE_LESS;
      end
      CH_GREATER: begin
        r.emit = 1'b0;
        r.mode = MODE_GREATER;
      end
      CH_EQUAL: begin
        r.emit = 1'b0;
        r.mode = MODE_EQUAL;
      end
      CH_SLASH: begin
        r.emit = 1'b0;
        r.mode = MODE_SLASH;
      end
      CH_NEWLINE: begin
        r.emit    = 1'b0;
        r.newline = 1'b1;
      end
      CH_QUOTE: begin
        r.emit  = 1'b0;
        r.mode  = MODE_STRING;
        r.quote = 1'b1;
      end
      default: r.kind = K_BAD;
    endcase
    return r;
  endfunction

  // Token of a pending one-character operator.
  function automatic kind_t op_kind(mode_t m);
    kind_t k;
    case (m)
      MODE_BANG:    k = K_BANG;
      MODE_LESS:    k = K_LESS;
      MODE_GREATER: k = K_GREATER;
      MODE_EQUAL:   k = K_EQUAL;
      default:      k = K_SLASH;
    endcase
    return k;
  endfunction

  // Token of an operator followed by '='.
  function automatic kind_t op_eq_kind(mode_t m);
    kind_t k;
    case (m)
      MODE_BANG:    k = K_BANG_EQUAL;
      MODE_LESS:    k = K_LESS_EQUAL;
      MODE_GREATER: k = K_GREATER_EQUAL;
      default:      k = K_EQUAL_EQUAL;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/pls_queue.sv @@
module pls_queue #(
  parameter int WIDTH = pls_pkg::QUEUE_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pls_pkg::push_t      push,
  input  logic [WIDTH-1:0]    wr_data0,
  input  logic [WIDTH-1:0]    wr_data1,
  output logic                room,
  output logic                rd_valid,
  input  logic                rd_pop,
  output logic [WIDTH-1:0]    rd_data
);

  localparam int DEPTH = pls_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, wptr_p1;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] n_push;
  logic             pop;

  assign pop      = rd_valid & rd_pop;
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  // Room for the two results a single byte may complete.
  assign room     = (cnt_r <= CNT_W'(DEPTH - 2));
  assign wptr_p1  = PTR_W'(wptr_r + 1'b1);

  always_comb begin
    n_push   = CNT_W'(push.first) + CNT_W'(push.second);
    cnt_nxt  = CNT_W'(cnt_r + n_push - CNT_W'(pop));
    wptr_nxt = PTR_W'(wptr_r + n_push[PTR_W-1:0]);
    rptr_nxt = pop ? PTR_W'(rptr_r + 1'b1) : rptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wptr_r] <= wr_data0;
    end
    if (push.second) begin
      mem_r[wptr_p1] <= wr_data1;
    end
  end

endmodule

@@ hw/rtl/pls_core.sv @@
module pls_core #(
  parameter int LINE_BITS = pls_pkg::LINE_BITS_DEF,
  parameter int POS_BITS  = pls_pkg::POS_BITS_DEF,
  localparam int REC_W    = 1 + pls_pkg::KIND_W + LINE_BITS + 2 * POS_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         in_byte,
  input  logic               in_eot,
  output pls_pkg::push_t     push,
  output logic [REC_W-1:0]   rec0,
  output logic [REC_W-1:0]   rec1,
  output pls_pkg::mode_t     mode
);

  pls_pkg::mode_t         mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt, line_sat;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic [POS_BITS-1:0]    start_r, start_nxt;
  logic [POS_BITS-1:0]    len_r, len_nxt, len_sat;

  pls_pkg::normal_t       nc;
  logic                   run_normal;
  logic                   pre_vld, post_vld;
  pls_pkg::kind_t         pre_kind, post_kind;
  logic [POS_BITS-1:0]    pre_start, post_start, pre_len;

  assign mode     = mode_r;
  assign line_sat = (&line_r) ? line_r : LINE_BITS'(line_r + 1'b1);
  assign len_sat  = (&len_r) ? len_r : POS_BITS'(len_r + 1'b1);

  always_comb begin
    nc         = pls_pkg::lex_byte(in_byte);
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    run_normal = 1'b0;
    pre_vld    = 1'b0;
    pre_kind   = pls_pkg::K_EOF;
    pre_start  = start_r;
    pre_len    = '0;
    post_vld   = 1'b0;
    post_kind  = nc.kind;
    post_start = pos_r;

    if (in_eot) begin
      // Flush whatever is pending, then close the text with EOF.
      unique case (mode_r) inside
        pls_pkg::MODE_BANG, pls_pkg::MODE_LESS, pls_pkg::MODE_GREATER,
        pls_pkg::MODE_EQUAL, pls_pkg::MODE_SLASH: begin
          pre_vld  = 1'b1;
          pre_kind = pls_pkg::op_kind(mode_r);
        end
        pls_pkg::MODE_STRING: begin
          pre_vld  = 1'b1;
          pre_kind = pls_pkg::K_UNTERM;
        end
        default: pre_vld = 1'b0;
      endcase
      post_vld   = 1'b1;
      post_kind  = pls_pkg::K_EOF;
      post_start = start_r;
      mode_nxt   = pls_pkg::MODE_NORMAL;
      line_nxt   = LINE_BITS'(1);
      pos_nxt    = '0;
      start_nxt  = '0;
      len_nxt    = '0;
    end else begin
      pos_nxt = POS_BITS'(pos_r + 1'b1);
      unique case (mode_r) inside
        pls_pkg::MODE_BANG, pls_pkg::MODE_LESS, pls_pkg::MODE_GREATER,
        pls_pkg::MODE_EQUAL: begin
          mode_nxt = pls_pkg::MODE_NORMAL;
          pre_vld  = 1'b1;
          if (in_byte == pls_pkg::CH_EQUAL) begin
            pre_kind = pls_pkg::op_eq_kind(mode_r);
          end else begin
            pre_kind   = pls_pkg::op_kind(mode_r);
            run_normal = 1'b1;
          end
        end
        pls_pkg::MODE_SLASH: begin
          if (in_byte == pls_pkg::CH_SLASH) begin
            mode_nxt = pls_pkg::MODE_COMMENT;
          end else begin
            pre_vld    = 1'b1;
            pre_kind   = pls_pkg::K_SLASH;
            run_normal = 1'b1;
          end
        end
        pls_pkg::MODE_COMMENT: begin
          run_normal = (in_byte == pls_pkg::CH_NEWLINE);
        end
        pls_pkg::MODE_STRING: begin
          if (in_byte == pls_pkg::CH_QUOTE) begin
            mode_nxt = pls_pkg::MODE_NORMAL;
            pre_vld  = 1'b1;
            pre_kind = pls_pkg::K_STRING;
            pre_len  = len_r;
          end else begin
            if (in_byte == pls_pkg::CH_NEWLINE) begin
              line_nxt = line_sat;
            end
            len_nxt = len_sat;
          end
        end
        default: run_normal = 1'b1;
      endcase

      if (run_normal) begin
        mode_nxt  = nc.mode;
        start_nxt = pos_r;
        post_vld  = nc.emit;
        if (nc.newline) begin
          line_nxt = line_sat;
        end
        if (nc.quote) begin
          len_nxt = '0;
        end
      end
    end

    // Every token of one step carries the line count from before the step.
    push.first  = fire & (pre_vld | post_vld);
    push.second = fire & pre_vld & post_vld;
    if (pre_vld) begin
      rec0 = {~post_vld, pre_len, pre_start, line_r, pre_kind};
    end else begin
      rec0 = {1'b1, POS_BITS'(0), post_start, line_r, post_kind};
    end
    rec1 = {1'b1, POS_BITS'(0), post_start, line_r, post_kind};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pls_pkg::MODE_NORMAL;
      line_r  <= LINE_BITS'(1);
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
    end
  end

endmodule

@@ hw/rtl/punctuation_string_lexer.sv @@
// Channel   Direction  Payload                                         Transaction when
// in_*      slave      tdata: byte_value; tlast: end_of_text           in_tvalid & in_tready
// out_*     master     tdata: kind, line, start, length; tlast: last   out_tvalid & out_tready
//
// One input transaction is taken per cycle while the queue has room. A byte lands in
// the input register, is scanned once the queue has room, and its tokens (zero, one or
// two) are written to a four-entry result queue, from which the output side reads.
// The queue drains one result per cycle while the receiver is ready, and the input
// stalls whenever the queue holds more than two results. Reset (rst_n low,
// synchronous) empties the queue and puts the scanner in the normal mode at line one,
// offset zero.
module punctuation_string_lexer #(
  parameter int LINE_BITS = pls_pkg::LINE_BITS_DEF,
  parameter int POS_BITS  = pls_pkg::POS_BITS_DEF,
  localparam int OUT_FLD_W  = pls_pkg::KIND_W + LINE_BITS + 2 * POS_BITS,
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Source bytes.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] byte_value
  input  logic                  in_tlast,   // end_of_text
  // Tokens.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // From bit 0 up: token_kind, line_number, lexeme_start, literal_length, zero fill.
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast   // last_result
);

  localparam int REC_W = 1 + OUT_FLD_W;

  // Input register. It advances whenever the scanner consumes its byte, so
  // a new byte can be taken in every cycle the queue has room.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;
  logic       fire;
  logic       room;

  pls_pkg::push_t   push;
  pls_pkg::mode_t   core_mode;
  logic [REC_W-1:0] rec0, rec1, head;

  assign fire      = in_vld_r & room;
  assign in_tready = ~in_vld_r | fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  // Scanner: mode, counters and the token decision for one byte.
  pls_core #(
    .LINE_BITS (LINE_BITS),
    .POS_BITS  (POS_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_byte_r),
    .in_eot  (in_eot_r),
    .push    (push),
    .rec0    (rec0),
    .rec1    (rec1),
    .mode    (core_mode)
  );

  // Result queue, also the output register of the master side.
  pls_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data0 (rec0),
    .wr_data1 (rec1),
    .room     (room),
    .rd_valid (out_tvalid),
    .rd_pop   (out_tready),
    .rd_data  (head)
  );

  assign out_tdata = OUT_DATA_W'(head[OUT_FLD_W-1:0]);
  assign out_tlast = head[REC_W-1];

  // The end marker always yields at least the EOF token.
  a_eot_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_eot_r |-> push.first)
    else $error("end marker produced no token");

  // After the end marker the scanner is back in the normal mode.
  a_eot_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_eot_r |=> core_mode == pls_pkg::MODE_NORMAL)
    else $error("scanner mode not cleared after end marker");

  // An EOF token is always the final result of its transaction.
  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[pls_pkg::KIND_W-1:0] == pls_pkg::K_EOF |-> out_tlast)
    else $error("EOF token without last flag");

  // A second token in one step is only ever pushed together with a first.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> push.first && !rec0[REC_W-1])
    else $error("token pair pushed out of order");

endmodule

@@ tb/sv/punctuation_string_lexer_test.sv @@
`timescale 1ns / 1ps

module punctuation_string_lexer_test;

  // Expected token as it appears on the output side, plus its last flag.
  typedef struct packed {
    pls_pkg::kind_t kind;
    logic [15:0]    line;
    logic [19:0]    start;
    logic [19:0]    length;
    logic           last;
  } token_t;

  // Scoreboard: it keeps its own copy of the scanner state and turns every
  // accepted input transaction into the tokens it should complete. Results
  // are then matched in order against the oldest expected token.
  class token_scoreboard;
    token_t         expected_tokens[$];
    int             errors;
    int             bytes_noted;
    int             texts_done;
    int             tokens_checked;
    pls_pkg::mode_t mode;
    logic [15:0]    line_cnt;
    logic [19:0]    byte_pos;
    logic [19:0]    lex_start;
    logic [19:0]    str_len;

    function void reset_state();
      mode      = pls_pkg::MODE_NORMAL;
      line_cnt  = 16'd1;
      byte_pos  = '0;
      lex_start = '0;
      str_len   = '0;
    endfunction

    function int pending();
      return expected_tokens.size();
    endfunction

    function void push_token(pls_pkg::kind_t k, logic [19:0] len);
      token_t t;
      t.kind   = k;
      t.line   = line_cnt;
      t.start  = lex_start;
      t.length = len;
      t.last   = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    // The line counter sticks at its maximum instead of wrapping.
    function void count_line();
      if (line_cnt != 16'hFFFF) line_cnt++;
    endfunction

    // Token of an operator that turned out to stand alone.
    function pls_pkg::kind_t single_kind(pls_pkg::mode_t m);
      case (m)
        pls_pkg::MODE_BANG:    return pls_pkg::K_BANG;
        pls_pkg::MODE_LESS:    return pls_pkg::K_LESS;
        pls_pkg::MODE_GREATER: return pls_pkg::K_GREATER;
        pls_pkg::MODE_EQUAL:   return pls_pkg::K_EQUAL;
        default:               return pls_pkg::K_SLASH;
      endcase
    endfunction

    // Scan a byte that starts a new lexeme.
    function void scan_fresh(logic [7:0] c);
      lex_start = byte_pos;
      mode      = pls_pkg::MODE_NORMAL;
      case (c)
        pls_pkg::CH_LPAREN:  push_token(pls_pkg::K_LPAREN, '0);
        pls_pkg::CH_RPAREN:  push_token(pls_pkg::K_RPAREN, '0);
        pls_pkg::CH_LBRACE:  push_token(pls_pkg::K_LBRACE, '0);
        pls_pkg::CH_RBRACE:  push_token(pls_pkg::K_RBRACE, '0);
        pls_pkg::CH_COMMA:   push_token(pls_pkg::K_COMMA, '0);
        pls_pkg::CH_DOT:     push_token(pls_pkg::K_DOT, '0);
        pls_pkg::CH_MINUS:   push_token(pls_pkg::K_MINUS, '0);
        pls_pkg::CH_PLUS:    push_token(pls_pkg::K_PLUS, '0);
        pls_pkg::CH_SEMI:    push_token(pls_pkg::K_SEMI, '0);
        pls_pkg::CH_STAR:    push_token(pls_pkg::K_STAR, '0);
        pls_pkg::CH_BANG:    mode = pls_pkg::MODE_BANG;
        pls_pkg::CH_LESS:    mode = pls_pkg::MODE_LESS;
        pls_pkg::CH_GREATER: mode = pls_pkg::MODE_GREATER;
        pls_pkg::CH_EQUAL:   mode = pls_pkg::MODE_EQUAL;
        pls_pkg::CH_SLASH:   mode = pls_pkg::MODE_SLASH;
        pls_pkg::CH_NEWLINE: count_line();
        pls_pkg::CH_QUOTE: begin
          mode    = pls_pkg::MODE_STRING;
          str_len = '0;
        end
        default:             push_token(pls_pkg::K_BAD, '0);
      endcase
    endfunction

    function void accept_byte(logic [7:0] c, logic eot);
      int     n_prior;
      token_t t;
      n_prior = expected_tokens.size();
      bytes_noted++;
      if (eot) begin
        // Flush whatever is pending, then close the text and start afresh.
        case (mode)
          pls_pkg::MODE_BANG, pls_pkg::MODE_LESS, pls_pkg::MODE_GREATER,
          pls_pkg::MODE_EQUAL, pls_pkg::MODE_SLASH:
            push_token(single_kind(mode), '0);
          pls_pkg::MODE_STRING: push_token(pls_pkg::K_UNTERM, '0);
          default: ;
        endcase
        push_token(pls_pkg::K_EOF, '0);
        texts_done++;
        reset_state();
      end else begin
        case (mode)
          pls_pkg::MODE_BANG, pls_pkg::MODE_LESS, pls_pkg::MODE_GREATER,
          pls_pkg::MODE_EQUAL: begin
            if (c == pls_pkg::CH_EQUAL) begin
              push_token(pls_pkg::kind_t'(single_kind(mode) + 5'd1), '0);
              mode = pls_pkg::MODE_NORMAL;
            end else begin
              push_token(single_kind(mode), '0);
              scan_fresh(c);
            end
          end
          pls_pkg::MODE_SLASH: begin
            if (c == pls_pkg::CH_SLASH) begin
              mode = pls_pkg::MODE_COMMENT;
            end else begin
              push_token(pls_pkg::K_SLASH, '0);
              scan_fresh(c);
            end
          end
          pls_pkg::MODE_COMMENT: begin
            if (c == pls_pkg::CH_NEWLINE) scan_fresh(c);
          end
          pls_pkg::MODE_STRING: begin
            if (c == pls_pkg::CH_QUOTE) begin
              mode = pls_pkg::MODE_NORMAL;
              push_token(pls_pkg::K_STRING, str_len);
            end else begin
              if (c == pls_pkg::CH_NEWLINE) count_line();
              if (str_len != '1) str_len++;
            end
          end
          default: scan_fresh(c);
        endcase
        byte_pos++;
      end
      if (expected_tokens.size() > n_prior) begin
        t      = expected_tokens[expected_tokens.size() - 1];
        t.last = 1'b1;
        expected_tokens[expected_tokens.size() - 1] = t;
      end
    endfunction

    function void check_token(logic [63:0] data, logic last);
      token_t t;
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token, expected none, got data=%h last=%0b",
                 $time, data, last);
        return;
      end
      t = expected_tokens.pop_front();
      tokens_checked++;
      if (data[4:0] !== t.kind || data[20:5] !== t.line || data[40:21] !== t.start ||
          data[60:41] !== t.length || data[63:61] !== 3'b000 || last !== t.last) begin
        errors++;
        $display("%0t: token mismatch, expected kind=%0d line=%0d start=%0d len=%0d last=%0b",
                 $time, t.kind, t.line, t.start, t.length, t.last);
        $display("%0t:                 actual kind=%0d line=%0d start=%0d len=%0d last=%0b fill=%0d",
                 $time, data[4:0], data[20:5], data[40:21], data[60:41], last, data[63:61]);
      end
    endfunction
  endclass

  // Single-character punctuation and the operators that may take a trailing '='.
  localparam logic [7:0] PUNCT [10] = '{pls_pkg::CH_LPAREN, pls_pkg::CH_RPAREN,
                                        pls_pkg::CH_LBRACE, pls_pkg::CH_RBRACE,
                                        pls_pkg::CH_COMMA, pls_pkg::CH_DOT,
                                        pls_pkg::CH_MINUS, pls_pkg::CH_PLUS,
                                        pls_pkg::CH_SEMI, pls_pkg::CH_STAR};
  localparam logic [7:0] OPS [4] = '{pls_pkg::CH_BANG, pls_pkg::CH_LESS,
                                     pls_pkg::CH_GREATER, pls_pkg::CH_EQUAL};

  // A compact opening text: every punctuation token, an operator pair, an
  // operator followed by another token, a lone slash, a string that spans a
  // newline and a comment that is still open when the text ends.
  localparam logic [7:0] OPENING [24] = '{
    pls_pkg::CH_LPAREN, pls_pkg::CH_RPAREN, pls_pkg::CH_LBRACE, pls_pkg::CH_RBRACE,
    pls_pkg::CH_COMMA, pls_pkg::CH_DOT, pls_pkg::CH_MINUS, pls_pkg::CH_PLUS,
    pls_pkg::CH_SEMI, pls_pkg::CH_STAR, pls_pkg::CH_BANG, pls_pkg::CH_EQUAL,
    pls_pkg::CH_LESS, pls_pkg::CH_LPAREN, pls_pkg::CH_EQUAL, 8'h00,
    pls_pkg::CH_SLASH, 8'h20, pls_pkg::CH_QUOTE, pls_pkg::CH_NEWLINE,
    pls_pkg::CH_QUOTE, pls_pkg::CH_SLASH, pls_pkg::CH_SLASH, 8'hFF};

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;

  // Idle mix of the current phase, in percent, and a pending receiver hold-off.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;

  token_scoreboard lexer_sb;

  punctuation_string_lexer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: ready is redrawn at every falling edge from the phase's stall
  // rate. A hold-off request keeps ready low for that many whole cycles, which
  // lets the result queue fill up and back-pressure the input side.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every output transaction is checked at the rising edge that completes it.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) lexer_sb.check_token(out_tdata, out_tlast);
  end

  // Offer one input transaction. The task is entered at a falling edge and
  // returns at the falling edge after the transaction was accepted, so that
  // valid can stay high across back-to-back transactions.
  task automatic send_item(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    lexer_sb.accept_byte(b, eot);
    @(negedge clk);
  endtask

  // One random source text, built mostly from well-formed lexemes with random
  // content, with some stray bytes mixed in, and always closed by the end
  // marker (whose byte field is random, since the block must ignore it).
  task automatic send_random_text();
    int         pieces;
    int         sel;
    int         n;
    logic [7:0] c;
    pieces = $urandom_range(0, 24);
    for (int i = 0; i < pieces; i++) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        send_item(PUNCT[$urandom_range(9)], 1'b0);
      end else if (sel < 45) begin
        send_item(OPS[$urandom_range(3)], 1'b0);
        if ($urandom_range(1)) send_item(pls_pkg::CH_EQUAL, 1'b0);
      end else if (sel < 52) begin
        // A slash on its own; whatever comes next decides what it becomes.
        send_item(pls_pkg::CH_SLASH, 1'b0);
      end else if (sel < 62) begin
        send_item(pls_pkg::CH_SLASH, 1'b0);
        send_item(pls_pkg::CH_SLASH, 1'b0);
        n = $urandom_range(0, 12);
        for (int j = 0; j < n; j++) begin
          c = 8'($urandom_range(255));
          if (c == pls_pkg::CH_NEWLINE) c = c ^ 8'h01;
          send_item(c, 1'b0);
        end
        // Most comments end at a newline; the rest run into the next piece
        // or up to the end marker.
        if ($urandom_range(9) != 0) send_item(pls_pkg::CH_NEWLINE, 1'b0);
      end else if (sel < 77) begin
        send_item(pls_pkg::CH_QUOTE, 1'b0);
        n = $urandom_range(0, 12);
        for (int j = 0; j < n; j++) begin
          c = 8'($urandom_range(255));
          if (c == pls_pkg::CH_QUOTE) c = pls_pkg::CH_NEWLINE;
          send_item(c, 1'b0);
        end
        if ($urandom_range(9) != 0) send_item(pls_pkg::CH_QUOTE, 1'b0);
      end else if (sel < 85) begin
        send_item(pls_pkg::CH_NEWLINE, 1'b0);
      end else if (sel < 90) begin
        send_item(8'h20, 1'b0);
      end else begin
        send_item(8'($urandom_range(255)), 1'b0);
      end
    end
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Hold the sender until every expected token has been seen.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (lexer_sb.pending() != 0) @(negedge clk);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct, input int n_items);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target         = lexer_sb.bytes_noted + n_items;
    while (lexer_sb.bytes_noted < target) send_random_text();
    drain();
  endtask

  initial begin
    lexer_sb = new;
    lexer_sb.reset_state();

    // Synchronous reset held low at the start; everything after runs on falling edges.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: the opening text with its end marker carrying an all-ones
    // byte, then a pending operator cut off by the end, an empty text and an
    // unterminated string.
    foreach (OPENING[i]) send_item(OPENING[i], 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(pls_pkg::CH_GREATER, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h5A, 1'b1);
    send_item(pls_pkg::CH_QUOTE, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h00, 1'b1);
    drain();

    // Back-pressure: the receiver holds off for a long stretch while a burst
    // of single-token bytes keeps coming, so the queue fills and the input
    // side must stall until the receiver opens up again.
    hold_request = 64;
    for (int i = 0; i < 20; i++) send_item(PUNCT[i % 10], 1'b0);
    send_item(8'h00, 1'b1);
    drain();

    // Random texts under the four idle mixes.
    random_phase(0, 0, 460);
    random_phase(46, 0, 460);
    random_phase(0, 46, 460);
    random_phase(6, 6, 460);

    // A quiet stretch at the end catches any token the block emits beyond the last one.
    repeat (10) @(negedge clk);

    $display("Lexed %0d source bytes in %0d texts and checked %0d tokens.",
             lexer_sb.bytes_noted, lexer_sb.texts_done, lexer_sb.tokens_checked);
    $display("Covered a long receiver hold-off, full drains and four idle mixes.");
    if (lexer_sb.errors == 0 && lexer_sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pls_pkg.sv
hw/rtl/pls_queue.sv
hw/rtl/pls_core.sv
hw/rtl/punctuation_string_lexer.sv
tb/sv/punctuation_string_lexer_test.sv
